// ===== src/hfa_pkg.sv =====
// package for the half-float adder: special encodings and field widths
// no dependencies
`default_nettype none
package hfa_pkg;
    localparam int HalfW = 16;
    localparam logic [15:0] HF_PINF = 16'h7C00;
    localparam logic [15:0] HF_NINF = 16'hFC00;
    localparam logic [15:0] HF_NAN  = 16'hFFFF;
    localparam int Bias  = 15;
    localparam int Guard = 30;
endpackage
`default_nettype wire

// ===== src/half_float_adder_top.sv =====
// half-float adder top level: input register, combinational add, result register
// depends on hfa_pkg
// the done strobe with the sum follows start through the input register and the result register
// throughput: one operand pair per cycle, busy is always low
// the receiver cannot stall; each sum is shown for one cycle with done
// reset (rst_n, async, active low) clears the valid pipeline only
`default_nettype none
module half_float_adder_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [hfa_pkg::HalfW-1:0] operand_a,
    input  wire logic [hfa_pkg::HalfW-1:0] operand_b,
    output logic                           done,
    output logic [hfa_pkg::HalfW-1:0]      sum
);
    import hfa_pkg::*;

    logic        in_vld_reg;
    logic [15:0] a_reg, b_reg;
    logic        out_vld_reg;
    logic [15:0] sum_reg, sum_next;

    // exponents as signed values, range -14..16 before normalization
    logic              sa, sb, rs;
    logic signed [7:0] expa, expb, re, re1;
    logic [10:0]       ma0, mb0;
    logic [4:0]        d;
    logic [41:0]       big, small_al;
    logic [42:0]       raw;
    logic [12:0]       rm0;
    logic [12:0]       rm1;
    logic [11:0]       rm2;
    logic [3:0]        lz;
    logic              a_big;
    logic [11:0]       shd;
    logic [3:0]        dn;
    logic [11:0]       den;

    // round to nearest even of raw at the guard point
    function automatic logic [12:0] rne30(input logic [42:0] m);
        logic [12:0] q;
        logic        h, lo;
        begin
            q  = m[42:30];
            h  = m[29];
            lo = |m[28:0];
            rne30 = q + 13'(h & (q[0] | lo));
        end
    endfunction

    always_comb
    begin
        sa   = a_reg[15];
        sb   = b_reg[15];
        expa = (a_reg[14:10] == 5'd0) ? -8'sd14 : $signed({3'b0, a_reg[14:10]}) - 8'sd15;
        expb = (b_reg[14:10] == 5'd0) ? -8'sd14 : $signed({3'b0, b_reg[14:10]}) - 8'sd15;
        ma0  = {a_reg[14:10] != 5'd0, a_reg[9:0]};
        mb0  = {b_reg[14:10] != 5'd0, b_reg[9:0]};
        // larger exponent operand unshifted (at most 30 positions of shift)
        if (expa >= expb)
        begin
            d        = 5'(expa - expb);
            big      = {1'b0, ma0, 30'd0};
            small_al = {1'b0, mb0, 30'd0} >> d;
            re       = expa;
        end
        else
        begin
            d        = 5'(expb - expa);
            big      = {1'b0, mb0, 30'd0};
            small_al = {1'b0, ma0, 30'd0} >> d;
            re       = expb;
        end
        // which side holds the larger aligned magnitude
        a_big = (expa >= expb) ? (big > small_al) : (small_al > big);
        rm1 = 13'd0;
        rm2 = 12'd0;
        re1 = re;
        lz  = 4'd0;
        rs  = sa;
        sum_next = 16'd0;
        if (sa == sb)
        begin
            raw = {1'b0, big} + {1'b0, small_al};
            rm0 = rne30(raw);
            rm1 = rm0;
            if (rm0[11])
            begin
                rm1 = (rm0 >> 1) + 13'(rm0[0] & rm0[1]);
                re1 = re + 8'sd1;
                if (rm1[11])
                begin
                    rm1 = rm1 >> 1;
                    re1 = re + 8'sd2;
                end
            end
        end
        else
        begin
            rs  = a_big ? sa : sb;
            raw = (big > small_al) ? {1'b0, big - small_al} : {1'b0, small_al - big};
            rm0 = rne30(raw);
            rm1 = rm0;
            // leading zero count from bit 10 down
            lz = 4'd0;
            for (int k = 10; k >= 0; k--)
            begin
                if (rm0[k] && lz == 4'd0 && !(|(rm0[10:0] >> (k + 1))))
                    lz = 4'(10 - k);
            end
            rm1 = rm0 << lz;
            re1 = re - $signed({4'b0, lz});
        end
        rm2 = rm1[11:0];
        dn  = (re1 <= -8'sd14) ? 4'(-8'sd14 - re1) : 4'd0;
        shd = rm2 >> dn;
        if (dn == 4'd0)
            den = rm2;
        else
            den = shd + 12'(rm2[dn - 4'd1] & (shd[0] | |(rm2 & ((12'd1 << (dn - 4'd1)) - 12'd1))));
        if (a_reg == HF_NAN || b_reg == HF_NAN)
            sum_next = HF_NAN;
        else if (a_reg == HF_PINF || b_reg == HF_PINF)
            sum_next = (a_reg == HF_NINF || b_reg == HF_NINF) ? HF_NAN : HF_PINF;
        else if (a_reg == HF_NINF || b_reg == HF_NINF)
            sum_next = HF_NINF;
        else if (sa != sb && rm0 == 13'd0)
            sum_next = 16'd0;
        else if (re1 > 8'sd15)
            sum_next = rs ? HF_NINF : HF_PINF;
        else if (re1 <= -8'sd14)
            sum_next = {rs, 4'd0, den[10:0]};
        else
            sum_next = {rs, 5'(re1 + 8'sd15), rm2[9:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (in_vld_reg)
            sum_reg <= sum_next;
    end

    assign busy = 1'b0;
    assign done = out_vld_reg;
    assign sum  = sum_reg;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done) else $error("missing done");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2)) else $error("spurious done");
    a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && a_reg == HF_NAN) |=> sum == HF_NAN) else $error("nan lost");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_half_float_adder_top.sv =====
// testbench for half_float_adder_top: directed and random operand pairs, self-checking
// depends on hfa_pkg and the half_float_adder_top rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_half_float_adder_top;
    import hfa_pkg::*;

    typedef struct packed {
        logic [HalfW-1:0] a;
        logic [HalfW-1:0] b;
    } operand_pair_t;

    localparam int RandItems  = 500;
    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 8;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [HalfW-1:0] operand_a;
    logic [HalfW-1:0] operand_b;
    logic             done;
    logic [HalfW-1:0] sum;

    operand_pair_t    pending_pairs[$];
    logic [HalfW-1:0] expected_sums[$];
    int               mismatch_count;
    int               cycle_count;
    int               calm_left;
    bit               stimulus_ready;
    operand_pair_t    held_pair;

    // busy as sampled at the last rising edge, so the driver knows a transfer happened
    logic busy_at_edge;
    initial busy_at_edge = 1'b0;

    half_float_adder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .sum       (sum)
    );

    always #5 clk = ~clk;

    // shift right with round to nearest, ties to even; zero shift keeps the value
    function automatic logic [63:0] round_shift(input logic [63:0] m, input int n);
        logic [63:0] low_mask;
        logic        half_bit;
        begin
            if (n == 0)
                return m;
            if (n >= 63)
                return 64'd0;
            half_bit = m[n-1];
            low_mask = (64'd1 << (n - 1)) - 64'd1;
            if (half_bit && (m[n] || (m & low_mask) != 64'd0))
                m = m + (64'd1 << (n - 1));
            return m >> n;
        end
    endfunction

    // expected half-precision sum of one operand pair
    function automatic logic [HalfW-1:0] half_sum(input logic [HalfW-1:0] a,
                                                  input logic [HalfW-1:0] b);
        logic        sign_a, sign_b, res_sign;
        int          exp_a, exp_b, res_exp, k;
        logic [63:0] sig_a, sig_b, res_sig;
        logic [4:0]  exp_field;
        begin
            if (a == HF_NAN || b == HF_NAN)
                return HF_NAN;
            if (a == HF_PINF || b == HF_PINF)
                return (a == HF_NINF || b == HF_NINF) ? HF_NAN : HF_PINF;
            if (a == HF_NINF || b == HF_NINF)
                return HF_NINF;
            sign_a = a[15];
            sign_b = b[15];
            sig_a = {54'd0, a[9:0]};
            sig_b = {54'd0, b[9:0]};
            exp_a = 1 - Bias;
            exp_b = 1 - Bias;
            if (a[14:10] != 5'd0)
            begin
                exp_a = int'(a[14:10]) - Bias;
                sig_a[10] = 1'b1;
            end
            if (b[14:10] != 5'd0)
            begin
                exp_b = int'(b[14:10]) - Bias;
                sig_b[10] = 1'b1;
            end
            sig_a = sig_a << Guard;
            sig_b = sig_b << Guard;
            if (exp_a < exp_b)
            begin
                sig_a = sig_a >> (exp_b - exp_a);
                exp_a = exp_b;
            end
            else if (exp_b < exp_a)
                sig_b = sig_b >> (exp_a - exp_b);
            res_exp = exp_a;
            if (sign_a == sign_b)
            begin
                res_sign = sign_a;
                res_sig = round_shift(sig_a + sig_b, Guard);
                if (res_sig[11])
                begin
                    // carry out: round again by one bit, maybe shift once more
                    res_sig = round_shift(res_sig, 1);
                    res_exp++;
                    if (res_sig[11])
                    begin
                        res_sig = res_sig >> 1;
                        res_exp++;
                    end
                end
            end
            else
            begin
                res_sign = (sig_a > sig_b) ? sign_a : sign_b;
                res_sig = (sig_a > sig_b) ? sig_a - sig_b : sig_b - sig_a;
                res_sig = round_shift(res_sig, Guard);
                if (res_sig == 64'd0)
                    return 16'h0000;
                for (k = 0; k < 11 && !res_sig[10]; k++)
                begin
                    res_sig = res_sig << 1;
                    res_exp--;
                end
            end
            if (res_exp > Bias)
                return res_sign ? HF_NINF : HF_PINF;
            if (res_exp <= 1 - Bias)
            begin
                res_sig = round_shift(res_sig, (1 - Bias) - res_exp);
                return {res_sign, res_sig[14:0]} & 16'h87FF;
            end
            exp_field = 5'(res_exp + Bias);
            return {res_sign, exp_field, res_sig[9:0]};
        end
    endfunction

    // random operand with a bias toward edge-of-range exponents and specials
    function automatic logic [HalfW-1:0] rand_half();
        int pick;
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: return HF_NAN;
                1: return HF_PINF;
                2: return HF_NINF;
                3: return {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom)};
                4: return {$urandom_range(0, 1) == 1, 5'd31, 10'($urandom)};
                5: return {$urandom_range(0, 1) == 1, 5'($urandom_range(1, 3)), 10'($urandom)};
                default: return 16'($urandom);
            endcase
        end
    endfunction

    task automatic queue_pair(input logic [HalfW-1:0] a, input logic [HalfW-1:0] b);
        operand_pair_t p;
        begin
            p.a = a;
            p.b = b;
            pending_pairs.push_back(p);
        end
    endtask

    // stimulus list: directed corners first, then random pairs
    initial
    begin
        operand_pair_t p;
        logic [HalfW-1:0] r;
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        operand_a = '0;
        operand_b = '0;
        mismatch_count = 0;
        cycle_count = 0;
        calm_left = 0;
        stimulus_ready = 1'b0;
        // nan operand, opposite infinities, one infinity
        queue_pair(HF_NAN, 16'h3C00);
        queue_pair(16'h3C00, HF_NAN);
        queue_pair(HF_PINF, HF_NINF);
        queue_pair(HF_NINF, HF_PINF);
        queue_pair(HF_PINF, 16'hC000);
        queue_pair(16'h1234, HF_NINF);
        // zeros of like and unlike sign
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h8000, 16'h8000);
        queue_pair(16'h8000, 16'h0000);
        // exact cancellation
        queue_pair(16'h3C00, 16'hBC00);
        queue_pair(16'hC500, 16'h4500);
        // carry out and double rounding, overflow
        queue_pair(16'h3FFF, 16'h3FFF);
        queue_pair(16'h7BFF, 16'h7BFF);
        queue_pair(16'h7BFF, 16'h0001);
        queue_pair(16'h7BFF, 16'h5000);
        // exponent field 31 with a nonzero fraction is an ordinary number
        queue_pair(16'h7C01, 16'h0000);
        queue_pair(16'hFFFE, 16'h7FFE);
        queue_pair(16'h7FFF, 16'hFFFE);
        // denormals and tiny differences
        queue_pair(16'h0001, 16'h0001);
        queue_pair(16'h03FF, 16'h0001);
        queue_pair(16'h0400, 16'h8001);
        queue_pair(16'h83FF, 16'h0400);
        // large exponent gap, sign of a difference
        queue_pair(16'h7800, 16'h8001);
        queue_pair(16'h3C00, 16'hC000);
        queue_pair(16'hFFFE, 16'hFFFE);
        for (i = 0; i < RandItems; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // near cancellation: opposite sign, close magnitude
                r = rand_half();
                p.a = r;
                p.b = {~r[15], r[14:0] ^ 15'($urandom_range(0, 3))};
            end
            else
            begin
                p.a = rand_half();
                p.b = rand_half();
            end
            pending_pairs.push_back(p);
        end
        stimulus_ready = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: issue at the falling edge, transfer happens at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && stimulus_ready)
        begin
            // a start refused at the last rising edge stays put, otherwise move on
            if (!start || !busy_at_edge)
            begin
                if (calm_left == 0 && $urandom_range(0, 99) == 0)
                    calm_left <= 300;
                else if (calm_left > 0)
                    calm_left <= calm_left - 1;
                if (pending_pairs.size() > 0 && (calm_left > 0 || $urandom_range(0, 99) >= 7))
                begin
                    held_pair = pending_pairs.pop_front();
                    start <= 1'b1;
                    operand_a <= held_pair.a;
                    operand_b <= held_pair.b;
                end
                else
                begin
                    start <= 1'b0;
                    operand_a <= 16'($urandom);
                    operand_b <= 16'($urandom);
                end
            end
        end
    end

    // monitor: record transfers and check sums at the rising edge
    always @(posedge clk)
    begin
        logic [HalfW-1:0] want;
        busy_at_edge <= busy;
        if (rst_n)
        begin
            if (start && !busy)
                expected_sums.push_back(half_sum(operand_a, operand_b));
            if (done)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected sum %h with nothing outstanding", sum);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (sum !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("sum mismatch: expected %h, actual %h", want, sum);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // end of run: all transfers made, all sums seen, then a short drain
    initial
    begin
        wait (stimulus_ready && rst_n);
        wait (pending_pairs.size() == 0);
        @(posedge clk);
        while (start || expected_sums.size() > 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
